// ===== rtl/core/ddo_pkg.sv =====
// Shared types, constants and tables of the differential-drive odometry unit.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CordicStepsDef = 16;
  localparam int TickBitsDef    = 16;

  localparam int MulAW   = 36;
  localparam int MulBW   = 32;
  localparam int MulPW   = MulAW + MulBW;
  localparam int MulRW   = 56;
  localparam int DivNW   = 56;
  localparam int DivDW   = 24;
  localparam int CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgMpt = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdt = CfgIdxW'(1);

  localparam logic [31:0] MptReset = 32'd2698577;
  localparam logic [31:0] IdtReset = 32'd99297;
  localparam logic [31:0] UsPerS   = 32'd1000000;
  localparam logic [DivDW-1:0] Q16TwoPi = DivDW'(411775);

  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_16   = 2'd1,
    SH_17   = 2'd2,
    SH_30   = 2'd3
  } mul_sh_e;

  typedef struct packed {
    logic signed [15:0] left_ticks;
    logic signed [15:0] right_ticks;
    logic [23:0]        interval_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [19:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] turn_rate;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        value;
  } cfg_req_t;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
    mul_sh_e          sh;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MulRW-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] num;
    logic [DivDW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quo;
    logic [DivDW-1:0] rem;
  } div_rsp_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ddo_if.sv =====
// Valid/ready channel interfaces of the odometry unit: input, result and config.
// Depends on ddo_pkg for the payload types.
`timescale 1ns / 1ps
interface ddo_in_if;
  logic               valid;
  logic               ready;
  ddo_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  ddo_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddo_cfg_if;
  logic              valid;
  logic              ready;
  ddo_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ddo_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, with rounding shift.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
module ddo_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_pkg::mul_req_t req_i,
  output ddo_pkg::mul_rsp_t rsp_o
);

  localparam logic [5:0] Steps = 6'(ddo_pkg::MulBW);

  logic                          busy_q, busy_d;
  logic [5:0]                    cnt_q, cnt_d;
  logic [ddo_pkg::MulAW-1:0]     a_q;
  logic [ddo_pkg::MulBW-1:0]     b_q;
  ddo_pkg::mul_sh_e              sh_q;
  logic [ddo_pkg::MulPW-1:0]     acc_q;
  logic [ddo_pkg::MulAW:0]       part;
  logic [ddo_pkg::MulPW-1:0]     half, rnd, shifted;

  always_comb begin
    part = {1'b0, acc_q[ddo_pkg::MulPW-1:ddo_pkg::MulBW]}
         + (b_q[0] ? {1'b0, a_q} : '0);
    unique case (sh_q)
      ddo_pkg::SH_NONE: half = '0;
      ddo_pkg::SH_16:   half = ddo_pkg::MulPW'(1) << 15;
      ddo_pkg::SH_17:   half = ddo_pkg::MulPW'(1) << 16;
      ddo_pkg::SH_30:   half = ddo_pkg::MulPW'(1) << 29;
      default:          half = '0;
    endcase
    rnd = acc_q + half;
    unique case (sh_q)
      ddo_pkg::SH_NONE: shifted = rnd;
      ddo_pkg::SH_16:   shifted = rnd >> 16;
      ddo_pkg::SH_17:   shifted = rnd >> 17;
      ddo_pkg::SH_30:   shifted = rnd >> 30;
      default:          shifted = rnd;
    endcase
    rsp_o.done = busy_q && (cnt_q == Steps);
    rsp_o.res  = shifted[ddo_pkg::MulRW-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == Steps) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      sh_q  <= req_i.sh;
      acc_q <= '0;
    end else if (busy_q && (cnt_q != Steps)) begin
      acc_q <= {part, acc_q[ddo_pkg::MulBW-1:1]};
      b_q   <= b_q >> 1;
    end
  end

endmodule

// ===== rtl/core/ddo_div.sv =====
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
module ddo_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddo_pkg::div_req_t req_i,
  output ddo_pkg::div_rsp_t rsp_o
);

  localparam logic [5:0] Steps = 6'(ddo_pkg::DivNW);

  logic                      busy_q;
  logic [5:0]                cnt_q;
  logic [ddo_pkg::DivNW-1:0] num_q, quo_q;
  logic [ddo_pkg::DivDW-1:0] den_q, rem_q;
  logic [ddo_pkg::DivDW:0]   trial, diff;
  logic                      qbit;

  always_comb begin
    trial = {rem_q, num_q[ddo_pkg::DivNW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rsp_o.done = busy_q && (cnt_q == Steps);
    rsp_o.quo  = quo_q;
    rsp_o.rem  = rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == Steps) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q && (cnt_q != Steps)) begin
      rem_q <= qbit ? diff[ddo_pkg::DivDW-1:0] : trial[ddo_pkg::DivDW-1:0];
      quo_q <= {quo_q[ddo_pkg::DivNW-2:0], qbit};
      num_q <= num_q << 1;
    end
  end

endmodule

// ===== rtl/core/ddo_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle, cosine and sine in Q2.30.
// Depends on ddo_pkg for the angle constants and arctangent table.
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [19:0] heading_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int CntW = $clog2(CORDIC_STEPS + 1);
  localparam logic [CntW-1:0] Last = CntW'(CORDIC_STEPS);

  logic                   busy_q, flip_q;
  logic [CntW-1:0]        cnt_q;
  logic signed [33:0]     x_q, y_q, sx, sy;
  logic signed [35:0]     z_q, a0, a1, a2, step_ang;
  logic                   flip_d;

  always_comb begin
    a0 = {{2{heading_i[19]}}, heading_i, 14'b0};
    a1 = a0;
    if (a1 > ddo_pkg::Q30Pi) begin
      a1 = a1 - ddo_pkg::Q30TwoPi;
    end
    if (a1 < -ddo_pkg::Q30Pi) begin
      a1 = a1 + ddo_pkg::Q30TwoPi;
    end
    a2     = a1;
    flip_d = 1'b0;
    if (a1 > ddo_pkg::Q30HalfPi) begin
      a2     = a1 - ddo_pkg::Q30Pi;
      flip_d = 1'b1;
    end else if (a1 < -ddo_pkg::Q30HalfPi) begin
      a2     = a1 + ddo_pkg::Q30Pi;
      flip_d = 1'b1;
    end
    sx       = x_q >>> cnt_q;
    sy       = y_q >>> cnt_q;
    step_ang = $signed({4'b0, ddo_pkg::atan_q30(5'(cnt_q))});
    cos_o    = flip_q ? -x_q : x_q;
    sin_o    = flip_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == Last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= ddo_pkg::CordicGain;
      y_q    <= '0;
      z_q    <= a2;
      flip_q <= flip_d;
    end else if (busy_q && (cnt_q != Last)) begin
      if (!z_q[35]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - step_ang;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + step_ang;
      end
    end
  end

endmodule

// ===== rtl/core/diff_drive_odometry_unit.sv =====
// Top level of the differential-drive odometry unit: sequencer, state and result register.
// Depends on ddo_pkg, ddo_if, ddo_mul, ddo_div and ddo_cordic.
//
// Usage:
//   in_i   takes one request of left/right tick counts and interval in microseconds.
//   out_o  gives position, heading and velocities once for each request with a
//          nonzero interval; a zero interval is taken and produces nothing.
//   cfg_i  writes meters_per_tick (index 0) or inverse_double_track (index 1);
//          other indexes are ignored. Write only while the unit is idle.
// Timing:
//   each request passes through the serial multiplier (seven products) and the
//   serial divider (three divisions), used in turn, from acceptance to a valid
//   result; the next request is taken only after the unit is back in idle.
//   in_i.ready is high only while no request is in work; a new request may be
//   taken while the last result still waits in the output register.
// Reset:
//   position and heading clear to zero, registers return to their defaults.
//   A stalled receiver holds the result; the next one waits in the sequencer.
`timescale 1ns / 1ps
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDef,
  parameter int TICK_BITS    = ddo_pkg::TickBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  ddo_in_if.sink    in_i,
  ddo_out_if.source out_o,
  ddo_cfg_if.sink   cfg_i
);

  localparam bit HasSign = (TICK_BITS <= 16);
  localparam int SignIdx = HasSign ? TICK_BITS - 1 : 0;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MD   = 12'b000000000010,
    S_ME   = 12'b000000000100,
    S_MT   = 12'b000000001000,
    S_MX   = 12'b000000010000,
    S_MY   = 12'b000000100000,
    S_MVL  = 12'b000001000000,
    S_DVL  = 12'b000010000000,
    S_MVA  = 12'b000100000000,
    S_DVA  = 12'b001000000000,
    S_DH   = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_e;

  state_e             state_q, state_d;
  logic               st_q, st_d;
  logic               out_valid_q;
  ddo_pkg::out_item_t out_q;
  logic [31:0]        mpt_q, idt_q;
  logic signed [31:0] x_q, y_q;
  logic signed [19:0] h_q;

  logic [17:0]        lt_ext, rt_ext, lt_pad, rt_pad;
  logic signed [17:0] tsum, tdiff;
  logic               take, fin_go;

  logic [17:0]        summag_q, diffmag_q;
  logic               sneg_q, tneg_q;
  logic [23:0]        t_q;
  logic [35:0]        dmag_q, emag_q;
  logic [51:0]        tmag_q;
  logic signed [35:0] dx_q, dy_q;
  logic [ddo_pkg::DivNW-1:0] num_q;
  logic [31:0]        lin_q, ang_q;
  logic signed [19:0] hnew_q;

  logic signed [33:0] cos_w, sin_w, cos_abs, sin_abs;
  logic signed [52:0] hsum, hmag;
  logic signed [36:0] xs, ys;
  logic signed [31:0] x_new, y_new;
  logic               tbig;

  ddo_pkg::mul_req_t mul_req;
  ddo_pkg::mul_rsp_t mul_rsp;
  ddo_pkg::div_req_t div_req;
  ddo_pkg::div_rsp_t div_rsp;

  function automatic logic [31:0] sat_rate(input logic [ddo_pkg::DivNW-1:0] q,
                                           input logic neg, input logic big);
    logic [31:0] v;
    if (big || (q[ddo_pkg::DivNW-1:31] != '0)) begin
      v = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      v = neg ? -q[31:0] : q[31:0];
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // tick sign extension from the configured width
  always_comb begin
    lt_pad = {2'b00, in_i.data.left_ticks};
    rt_pad = {2'b00, in_i.data.right_ticks};
    for (int k = 0; k < 18; k++) begin
      if (!HasSign || (k < TICK_BITS - 1)) begin
        lt_ext[k] = lt_pad[k];
        rt_ext[k] = rt_pad[k];
      end else begin
        lt_ext[k] = lt_pad[SignIdx];
        rt_ext[k] = rt_pad[SignIdx];
      end
    end
    tsum  = $signed(lt_ext) + $signed(rt_ext);
    tdiff = $signed(rt_ext) - $signed(lt_ext);
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign take        = in_i.valid && in_i.ready;
  assign fin_go      = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    cos_abs = cos_w[33] ? -cos_w : cos_w;
    sin_abs = sin_w[33] ? -sin_w : sin_w;
    hsum    = 53'(h_q) + (tneg_q ? -$signed({1'b0, tmag_q}) : $signed({1'b0, tmag_q}));
    hmag    = hsum[52] ? -hsum : hsum;
    tbig    = (tmag_q[51:36] != '0);
    xs      = 37'(x_q) + 37'(dx_q);
    ys      = 37'(y_q) + 37'(dy_q);
    x_new   = sat32(xs);
    y_new   = sat32(ys);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    st_d    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (take && (in_i.data.interval_us != '0)) begin
          state_d = S_MD;
          st_d    = 1'b1;
        end
      end
      S_MD:  if (mul_rsp.done) begin state_d = S_ME;  st_d = 1'b1; end
      S_ME:  if (mul_rsp.done) begin state_d = S_MT;  st_d = 1'b1; end
      S_MT:  if (mul_rsp.done) begin state_d = S_MX;  st_d = 1'b1; end
      S_MX:  if (mul_rsp.done) begin state_d = S_MY;  st_d = 1'b1; end
      S_MY:  if (mul_rsp.done) begin state_d = S_MVL; st_d = 1'b1; end
      S_MVL: if (mul_rsp.done) begin state_d = S_DVL; st_d = 1'b1; end
      S_DVL: if (div_rsp.done) begin state_d = S_MVA; st_d = 1'b1; end
      S_MVA: if (mul_rsp.done) begin state_d = S_DVA; st_d = 1'b1; end
      S_DVA: if (div_rsp.done) begin state_d = S_DH;  st_d = 1'b1; end
      S_DH:  if (div_rsp.done) begin state_d = S_FIN; end
      S_FIN: if (fin_go) begin state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mul_req.start = st_q && (state_q != S_DVL) && (state_q != S_DVA)
                    && (state_q != S_DH);
    mul_req.a     = '0;
    mul_req.b     = '0;
    mul_req.sh    = ddo_pkg::SH_NONE;
    unique case (state_q)
      S_MD:  begin mul_req.a = 36'(summag_q);  mul_req.b = mpt_q;
                   mul_req.sh = ddo_pkg::SH_17; end
      S_ME:  begin mul_req.a = 36'(diffmag_q); mul_req.b = mpt_q;
                   mul_req.sh = ddo_pkg::SH_16; end
      S_MT:  begin mul_req.a = emag_q;         mul_req.b = idt_q;
                   mul_req.sh = ddo_pkg::SH_16; end
      S_MX:  begin mul_req.a = dmag_q;         mul_req.b = cos_abs[31:0];
                   mul_req.sh = ddo_pkg::SH_30; end
      S_MY:  begin mul_req.a = dmag_q;         mul_req.b = sin_abs[31:0];
                   mul_req.sh = ddo_pkg::SH_30; end
      S_MVL: begin mul_req.a = dmag_q;         mul_req.b = ddo_pkg::UsPerS; end
      S_MVA: begin mul_req.a = tmag_q[35:0];   mul_req.b = ddo_pkg::UsPerS; end
      default: ;
    endcase
    div_req.start = st_q && ((state_q == S_DVL) || (state_q == S_DVA)
                    || (state_q == S_DH));
    div_req.num   = (state_q == S_DH) ? ddo_pkg::DivNW'(hmag[51:0]) : num_q;
    div_req.den   = (state_q == S_DH) ? ddo_pkg::Q16TwoPi : t_q;
  end

  ddo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (take && (in_i.data.interval_us != '0)),
    .heading_i (h_q),
    .cos_o     (cos_w),
    .sin_o     (sin_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mpt_q       <= ddo_pkg::MptReset;
      idt_q       <= ddo_pkg::IdtReset;
      x_q         <= '0;
      y_q         <= '0;
      h_q         <= '0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
        x_q         <= x_new;
        y_q         <= y_new;
        h_q         <= hnew_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        if (cfg_i.data.index == ddo_pkg::CfgMpt) begin
          mpt_q <= cfg_i.data.value;
        end else if (cfg_i.data.index == ddo_pkg::CfgIdt) begin
          idt_q <= cfg_i.data.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      summag_q  <= tsum[17] ? 18'(-tsum) : 18'(tsum);
      diffmag_q <= tdiff[17] ? 18'(-tdiff) : 18'(tdiff);
      sneg_q    <= tsum[17];
      tneg_q    <= tdiff[17];
      t_q       <= in_i.data.interval_us;
    end
    if (mul_rsp.done) begin
      unique case (state_q)
        S_MD: dmag_q <= mul_rsp.res[35:0];
        S_ME: emag_q <= mul_rsp.res[35:0];
        S_MT: tmag_q <= mul_rsp.res[51:0];
        S_MX: dx_q <= (sneg_q ^ cos_w[33]) ? -$signed(mul_rsp.res[35:0])
                                           : $signed(mul_rsp.res[35:0]);
        S_MY: dy_q <= (sneg_q ^ sin_w[33]) ? -$signed(mul_rsp.res[35:0])
                                           : $signed(mul_rsp.res[35:0]);
        S_MVL, S_MVA: num_q <= mul_rsp.res + ddo_pkg::DivNW'(t_q >> 1);
        default: ;
      endcase
    end
    if (div_rsp.done) begin
      unique case (state_q)
        S_DVL: lin_q <= sat_rate(div_rsp.quo, sneg_q, 1'b0);
        S_DVA: ang_q <= sat_rate(div_rsp.quo, tneg_q, tbig);
        S_DH:  hnew_q <= hsum[52] ? -$signed(div_rsp.rem[19:0])
                                  : $signed(div_rsp.rem[19:0]);
        default: ;
      endcase
    end
    if (fin_go) begin
      out_q.pos_x           <= x_new;
      out_q.pos_y           <= y_new;
      out_q.heading         <= hnew_q;
      out_q.linear_velocity <= lin_q;
      out_q.turn_rate       <= ang_q;
    end
  end

endmodule

// ===== sim/tb_diff_drive_odometry_unit.sv =====
// Self-checking testbench of diff_drive_odometry_unit: random and directed tick requests
// with random stalls on the request and result sides, checked against an odometry predictor class.
// Depends on ddo_pkg, diff_drive_odometry_unit and the ddo_in_if, ddo_out_if and ddo_cfg_if interfaces.
`timescale 1ns / 1ps
module tb_diff_drive_odometry_unit;

  localparam logic [ddo_pkg::CfgIdxW-1:0] CfgUnused = ddo_pkg::CfgIdxW'(2);
  localparam logic [ddo_pkg::CfgIdxW-1:0] CfgTop    = ddo_pkg::CfgIdxW'(255);
  localparam int DrainCycles = 600;

  class odometry_scoreboard;
    longint unsigned mpt, idt;
    longint x_pos, y_pos, head;
    ddo_pkg::out_item_t pending[$];
    int errors;
    longint atan_tab[31] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1};

    function new();
      mpt = ddo_pkg::MptReset;
      idt = ddo_pkg::IdtReset;
      x_pos = 0;
      y_pos = 0;
      head = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [ddo_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx == ddo_pkg::CfgMpt) mpt = val;
      else if (idx == ddo_pkg::CfgIdt) idt = val;
    endfunction

    // rounded product of magnitudes, capped at 2^62
    function longint unsigned mag_mul(longint unsigned a, longint unsigned b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p > (128'd1 << 62)) return 64'd1 << 62;
      return p[63:0];
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint per_second(longint unsigned m, bit neg, longint unsigned t);
      longint unsigned v;
      if (m >= (64'd1 << 36)) v = 64'd1 << 62;
      else v = (m * 64'd1000000 + t / 2) / t;
      return clip32(neg ? -longint'(v) : longint'(v));
    endfunction

    function void rotate(longint h, output longint c, output longint s);
      longint a, x, y, nx;
      bit flip;
      a = h * 16384;
      x = 652032874;
      y = 0;
      flip = 0;
      if (a > 64'sd3373259426) a -= 64'sd6746518852;
      if (a < -64'sd3373259426) a += 64'sd6746518852;
      if (a > 64'sd1686629713) begin
        a -= 64'sd3373259426;
        flip = 1;
      end else if (a < -64'sd1686629713) begin
        a += 64'sd3373259426;
        flip = 1;
      end
      for (int i = 0; i < ddo_pkg::CordicStepsDef && i < 31; i++) begin
        if (a >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          a -= atan_tab[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          a += atan_tab[i];
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint step_of(longint unsigned dm, bit dn, longint trig);
      bit neg;
      longint unsigned r;
      neg = dn != (trig < 0);
      r = mag_mul(dm, trig < 0 ? -trig : trig, 30);
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function void note_request(ddo_pkg::in_item_t it);
      longint l, r, sum, dif, c, s, turn;
      longint unsigned t, dm, em, tm;
      bit dn, tn;
      ddo_pkg::out_item_t e;
      l = it.left_ticks;
      r = it.right_ticks;
      t = it.interval_us;
      if (t == 0) return;
      sum = l + r;
      dif = r - l;
      dn = sum < 0;
      tn = dif < 0;
      dm = mag_mul(dn ? -sum : sum, mpt, 17);
      em = mag_mul(tn ? -dif : dif, mpt, 16);
      tm = mag_mul(em, idt, 16);
      rotate(head, c, s);
      x_pos = clip32(x_pos + step_of(dm, dn, c));
      y_pos = clip32(y_pos + step_of(dm, dn, s));
      turn = tn ? -longint'(tm) : longint'(tm);
      head = (head + turn) % 64'sd411775;
      e.pos_x = x_pos[31:0];
      e.pos_y = y_pos[31:0];
      e.heading = head[19:0];
      e.linear_velocity = 32'(per_second(dm, dn, t));
      e.turn_rate = 32'(per_second(tm, tn, t));
      pending.push_back(e);
    endfunction

    function void check_result(ddo_pkg::out_item_t got);
      ddo_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $display("%t unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.pos_x !== e.pos_x) begin
        $display("%t pos_x exp %0d got %0d", $realtime, e.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $display("%t pos_y exp %0d got %0d", $realtime, e.pos_y, got.pos_y);
        errors++;
      end
      if (got.heading !== e.heading) begin
        $display("%t heading exp %0d got %0d", $realtime, e.heading, got.heading);
        errors++;
      end
      if (got.linear_velocity !== e.linear_velocity) begin
        $display("%t linear_velocity exp %0d got %0d", $realtime, e.linear_velocity,
                 got.linear_velocity);
        errors++;
      end
      if (got.turn_rate !== e.turn_rate) begin
        $display("%t turn_rate exp %0d got %0d", $realtime, e.turn_rate,
                 got.turn_rate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit idle_on = 1'b1;
  odometry_scoreboard odo_sb = new();

  ddo_in_if  req_if();
  ddo_out_if res_if();
  ddo_cfg_if cfg_if();

  diff_drive_odometry_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) odo_sb.write_reg(cfg_if.data.index, cfg_if.data.value);
      if (req_if.valid && req_if.ready) odo_sb.note_request(req_if.data);
      if (res_if.valid && res_if.ready) odo_sb.check_result(res_if.data);
    end
  end

  // result side stalls
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = idle_on ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
        res_if.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  task automatic send_request(ddo_pkg::in_item_t it);
    int w;
    @(negedge clk_i);
    w = idle_on ? $urandom_range(0, 14) : 0;
    if (w > 0) begin
      req_if.valid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_ticks(int l, int r, int t);
    ddo_pkg::in_item_t it;
    it.left_ticks = 16'(l);
    it.right_ticks = 16'(r);
    it.interval_us = 24'(t);
    send_request(it);
  endtask

  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (odo_sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ddo_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic ddo_pkg::in_item_t rand_request();
    ddo_pkg::in_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.left_ticks = 16'(int'($urandom_range(0, 800)) - 400);
    it.right_ticks = 16'(int'($urandom_range(0, 800)) - 400);
    it.interval_us = 24'($urandom_range(1000, 200000));
    if (k < 12) begin
      it.left_ticks = 16'($urandom());
      it.right_ticks = 16'($urandom());
    end else if (k < 18) begin
      it.interval_us = 24'($urandom_range(1, 3));
    end else if (k < 24) begin
      it.interval_us = 24'($urandom());
    end else if (k < 28) begin
      it.interval_us = '0;
    end else if (k < 34) begin
      it.right_ticks = it.left_ticks;
    end else if (k < 40) begin
      it.right_ticks = -it.left_ticks;
    end
    return it;
  endfunction

  initial begin
    logic [31:0] mpt_set[6] = '{32'd2698577, 32'hFFFFFFFF, 32'd0, 32'd40000000,
                                32'd2698577, 32'h0};
    logic [31:0] idt_set[6] = '{32'd99297, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0,
                                32'd3000000, 32'h0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero interval, straight, spin
    send_ticks(100, 100, 100000);
    send_ticks(0, 0, 0);
    send_ticks(-32768, -32768, 1);
    send_ticks(32767, 32767, 24'hFFFFFF);
    send_ticks(-32768, 32767, 1);
    send_ticks(32767, -32768, 24'hFFFFFF);
    send_ticks(500, -500, 0);
    send_ticks(-3000, 3000, 50000);
    send_ticks(0, 0, 1);
    send_ticks(200, 300, 2);
    send_ticks(-200, -300, 3);
    settle();
    write_reg(ddo_pkg::CfgMpt, 32'hFFFFFFFF);
    write_reg(ddo_pkg::CfgIdt, 32'hFFFFFFFF);
    write_reg(CfgUnused, 32'h0);
    write_reg(CfgTop, 32'h12345678);
    send_ticks(32767, 32767, 1);
    send_ticks(-32768, 32767, 1);
    send_ticks(-32768, -32768, 24'hFFFFFF);
    send_ticks(1, -1, 5);
    send_ticks(0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 5) begin
        write_reg(ddo_pkg::CfgMpt, $urandom());
        write_reg(ddo_pkg::CfgIdt, $urandom());
      end else begin
        write_reg(ddo_pkg::CfgMpt, mpt_set[ph]);
        write_reg(ddo_pkg::CfgIdt, idt_set[ph]);
      end
      idle_on = (ph != 2);
      for (int n = 0; n < 300; n++) send_request(rand_request());
    end
    idle_on = 1'b1;
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (odo_sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (odo_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/ddo_pkg.sv
rtl/core/ddo_if.sv
rtl/core/ddo_mul.sv
rtl/core/ddo_div.sv
rtl/core/ddo_cordic.sv
rtl/core/diff_drive_odometry_unit.sv
sim/tb_diff_drive_odometry_unit.sv
